@@ src/rchk_pkg.sv @@
// Shared types and constants for the rectangle center Hilbert key block.
`default_nettype none
package rchk_pkg;

    localparam int COORD_W     = 32;
    localparam int COORD_FRAC  = 16;
    localparam int FRAC_SHIFT  = COORD_FRAC + 1;
    localparam int SUM_W       = COORD_W + 1;
    localparam int WIDE_W      = 64;
    localparam int CENTER_W    = 31;
    localparam int SAT_BIT     = FRAC_SHIFT + CENTER_W;
    localparam int LEVELS      = 32;
    localparam int LEVEL_W     = 5;
    localparam int KEY_W       = 2 * LEVELS;
    localparam int CFG_W       = 5;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_SHIFT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGHEST_BIT = 1'd1;

    localparam logic [CFG_W-1:0] SCALE_SHIFT_RESET = 5'd20;
    localparam logic [CFG_W-1:0] HIGHEST_BIT_RESET = 5'd31;

    localparam logic [CENTER_W-1:0] CENTER_MAX = {CENTER_W{1'b1}};

    typedef struct packed {
        logic [COORD_W-1:0] x_low;
        logic [COORD_W-1:0] y_low;
        logic [COORD_W-1:0] x_high;
        logic [COORD_W-1:0] y_high;
    } in_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] hilbert_index;
        logic             clipped;
    } out_word_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] yx;
        logic [KEY_W-1:0]   key;
        logic [LEVEL_W-1:0] top;
        logic               clipped;
    } stage_t;

endpackage
`default_nettype wire

@@ src/rchk_center.sv @@
// Front stage: scaled, saturated centers and the seed of the Hilbert chain.
`default_nettype none
module rchk_center
    import rchk_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               load,
    input  wire in_word_t           word,
    input  wire logic [CFG_W-1:0]   scale_shift,
    input  wire logic [LEVEL_W-1:0] highest_bit,
    output stage_t                  stage
);

    logic [SUM_W-1:0]    sum_x;
    logic [SUM_W-1:0]    sum_y;
    logic [WIDE_W-1:0]   wide_x;
    logic [WIDE_W-1:0]   wide_y;
    logic                sat_x;
    logic                sat_y;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic                valid_reg;
    logic                valid_next;
    stage_t              data_reg;
    stage_t              data_next;

    always_comb
    begin
        sum_x  = {1'b0, word.x_low} + {1'b0, word.x_high};
        sum_y  = {1'b0, word.y_low} + {1'b0, word.y_high};
        wide_x = {{(WIDE_W-SUM_W){1'b0}}, sum_x} << scale_shift;
        wide_y = {{(WIDE_W-SUM_W){1'b0}}, sum_y} << scale_shift;
        sat_x  = |wide_x[WIDE_W-1:SAT_BIT];
        sat_y  = |wide_y[WIDE_W-1:SAT_BIT];
        cx     = {1'b0, sat_x ? CENTER_MAX : wide_x[SAT_BIT-1:FRAC_SHIFT]};
        cy     = {1'b0, sat_y ? CENTER_MAX : wide_y[SAT_BIT-1:FRAC_SHIFT]};

        valid_next        = advance ? load : valid_reg;
        data_next.valid   = load;
        data_next.x       = cx;
        data_next.yx      = cy ^ cx;
        data_next.key     = '0;
        data_next.top     = highest_bit;
        data_next.clipped = sat_x | sat_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule
`default_nettype wire

@@ src/rchk_cell.sv @@
// One Hilbert level: emits a two-bit digit and transforms the running x.
`default_nettype none
module rchk_cell
    import rchk_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire stage_t             stage_in,
    output stage_t                  stage_out
);

    logic               active;
    logic               ybit;
    logic               xbit;
    logic [1:0]         digit;
    logic [COORD_W-1:0] x_new;
    logic               valid_reg;
    logic               valid_next;
    stage_t             data_reg;
    stage_t             data_next;

    always_comb
    begin
        active = level <= stage_in.top;
        ybit   = stage_in.yx[level];
        xbit   = stage_in.x[level];
        digit  = 2'd0;
        x_new  = stage_in.x;
        unique case ({ybit, xbit})
            2'b10:
            begin
                digit = 2'd1;
            end
            2'b11:
            begin
                digit = 2'd3;
                x_new = stage_in.x ^ ~stage_in.yx;
            end
            2'b00:
            begin
                digit = 2'd0;
                x_new = stage_in.x ^ stage_in.yx;
            end
            2'b01:
            begin
                digit = 2'd2;
            end
            default:
            begin
                digit = 2'd0;
            end
        endcase
        if (!active)
        begin
            digit = 2'd0;
            x_new = stage_in.x;
        end

        valid_next    = advance ? stage_in.valid : valid_reg;
        data_next     = stage_in;
        data_next.x   = x_new;
        data_next.key = {stage_in.key[KEY_W-3:0], digit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

@@ src/rect_center_hilbert_key.sv @@
// Top level: config registers, center stage and the chain of Hilbert level cells.
// Takes one rectangle per cycle while in_stall is low and returns one word per
// rectangle, in order. The word is held on out_data from the last of the 33 stage
// registers. The first of the 33 forms the scaled, saturated centers. The other
// 32 are a chain of cells, each handling one bit level, highest first. Levels
// above highest_bit append a zero digit and leave x unchanged.
// The whole chain holds while a finished word waits under out_stall and moves
// again as soon as it is taken.
// Config writes are always ready and are meant for an idle block.
`default_nettype none
module rect_center_hilbert_key
    import rchk_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_word_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_word_t                   out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    logic [CFG_W-1:0] scale_shift_reg;
    logic [CFG_W-1:0] scale_shift_next;
    logic [CFG_W-1:0] highest_bit_reg;
    logic [CFG_W-1:0] highest_bit_next;
    logic             advance;
    stage_t           chain [LEVELS+1];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        scale_shift_next = scale_shift_reg;
        highest_bit_next = highest_bit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCALE_SHIFT: scale_shift_next = cfg_data;
                CFG_HIGHEST_BIT: highest_bit_next = cfg_data;
                default:         scale_shift_next = scale_shift_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_shift_reg <= SCALE_SHIFT_RESET;
            highest_bit_reg <= HIGHEST_BIT_RESET;
        end
        else
        begin
            scale_shift_reg <= scale_shift_next;
            highest_bit_reg <= highest_bit_next;
        end
    end

    assign advance  = !(chain[LEVELS].valid && out_stall);
    assign in_stall = !advance;

    rchk_center u_center (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .load        (in_valid),
        .word        (in_data),
        .scale_shift (scale_shift_reg),
        .highest_bit (highest_bit_reg),
        .stage       (chain[0])
    );

    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        rchk_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .level     (LEVEL_W'(LEVELS - 1 - i)),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    assign out_valid              = chain[LEVELS].valid;
    assign out_data.hilbert_index = chain[LEVELS].key;
    assign out_data.clipped       = chain[LEVELS].clipped;

endmodule
`default_nettype wire
